>>> rtl/pget_pkg.sv
// ============================================================================
// pget_pkg
// Shared types and constants of the point graph edge table.
// ============================================================================
package pget_pkg;

    // Widths fixed by the item format.
    localparam int TOL_W      = 48;
    localparam int OUT_IDX_W  = 6;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;

    // Distance arithmetic: a magnitude at or above 2^24 saturates the square.
    localparam int SQ_IN_W    = 24;
    localparam int SQ_W       = 2 * SQ_IN_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int MAG_EXT_W  = 33;

    // Three axes for each of the begin and end probes.
    localparam int AXES       = 3;
    localparam int PROBES     = 2;
    localparam int NUM_LANES  = AXES * PROBES;

    localparam logic [TOL_W-1:0] TOL_RESET = 48'd256;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_DEL   = 2'd1,
        MODE_QUERY = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE = 2'd0,
        STAT_FULL = 2'd1,
        STAT_SKIP = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_APP_B,
        S_APP_E,
        S_ERD0,
        S_EWR0,
        S_ERD1,
        S_EWR1,
        S_FINISH
    } state_t;

    // Travels with a point memory read into the distance pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } pget_tag_t;

    // Comes back out of the distance pipeline.
    typedef struct packed {
        logic valid;
        logic last;
        logic begin_hit;
        logic end_hit;
    } pget_hit_t;

endpackage

>>> rtl/pget_ram.sv
// ============================================================================
// pget_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
module pget_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pget_match.sv
// ============================================================================
// pget_match
// Distance pipeline: compares one stored point against both probes per cycle.
// ============================================================================
module pget_match
    import pget_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int IDX_W      = 6
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  pget_tag_t                    issue,
    input  logic [IDX_W-1:0]             issue_idx,
    input  logic [AXES*COORD_BITS-1:0]   entry,
    input  logic [AXES*COORD_BITS-1:0]   begin_pt,
    input  logic [AXES*COORD_BITS-1:0]   end_pt,
    input  logic [TOL_W-1:0]             tol,
    output pget_hit_t                    hit,
    output logic [IDX_W-1:0]             hit_idx
);

    localparam int DIFF_W = COORD_BITS + 1;

    logic [NUM_LANES*COORD_BITS-1:0] probes;

    pget_tag_t          tag0_reg, tag1_reg, tag2_reg;
    logic [IDX_W-1:0]   idx0_reg, idx1_reg, idx2_reg, hit_idx_reg;
    pget_hit_t          hit_reg, hit_next;

    logic [SQ_IN_W-1:0] mag_next  [NUM_LANES];
    logic               sat_next  [NUM_LANES];
    logic [SQ_IN_W-1:0] mag_reg   [NUM_LANES];
    logic               sat1_reg  [NUM_LANES];
    logic [SQ_W-1:0]    sq_reg    [NUM_LANES];
    logic               sat2_reg  [NUM_LANES];

    assign probes = {end_pt, begin_pt};

    // Stage 1: absolute coordinate differences, saturated at 2^24.
    always_comb
    begin
        logic [COORD_BITS-1:0] p;
        logic [COORD_BITS-1:0] e;
        logic [DIFF_W-1:0]     diff;
        logic [DIFF_W-1:0]     absd;
        logic [MAG_EXT_W-1:0]  ext;
        for (int pr = 0; pr < PROBES; pr++)
        begin
            for (int ax = 0; ax < AXES; ax++)
            begin
                p    = probes[(pr*AXES + ax)*COORD_BITS +: COORD_BITS];
                e    = entry[ax*COORD_BITS +: COORD_BITS];
                diff = {p[COORD_BITS-1], p} - {e[COORD_BITS-1], e};
                absd = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
                ext  = MAG_EXT_W'(absd);
                mag_next[pr*AXES + ax] = ext[SQ_IN_W-1:0];
                sat_next[pr*AXES + ax] = |ext[MAG_EXT_W-1:SQ_IN_W];
            end
        end
    end

    // Stage 3: sum of squares against the tolerance.
    always_comb
    begin
        logic [SUM_W-1:0] sum_b;
        logic [SUM_W-1:0] sum_e;
        sum_b = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        sum_e = SUM_W'(sq_reg[3]) + SUM_W'(sq_reg[4]) + SUM_W'(sq_reg[5]);
        hit_next.valid     = tag2_reg.valid;
        hit_next.last      = tag2_reg.last;
        hit_next.begin_hit = tag2_reg.valid && !(sat2_reg[0] || sat2_reg[1] || sat2_reg[2])
                             && (sum_b < SUM_W'(tol));
        hit_next.end_hit   = tag2_reg.valid && !(sat2_reg[3] || sat2_reg[4] || sat2_reg[5])
                             && (sum_e < SUM_W'(tol));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag0_reg <= '0;
            tag1_reg <= '0;
            tag2_reg <= '0;
            hit_reg  <= '0;
        end
        else
        begin
            tag0_reg <= issue;
            tag1_reg <= tag0_reg;
            tag2_reg <= tag1_reg;
            hit_reg  <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx0_reg    <= issue_idx;
        idx1_reg    <= idx0_reg;
        idx2_reg    <= idx1_reg;
        hit_idx_reg <= idx2_reg;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            mag_reg[k]  <= mag_next[k];
            sat1_reg[k] <= sat_next[k];
            sq_reg[k]   <= mag_reg[k] * mag_reg[k];
            sat2_reg[k] <= sat1_reg[k];
        end
    end

    assign hit     = hit_reg;
    assign hit_idx = hit_idx_reg;

endmodule

>>> rtl/point_graph_edge_table_top.sv
// Each item scans the N stored points, one per cycle, into a four-stage distance pipeline
// (an empty table skips the scan); an add appends up to two new points, and an add or
// delete that goes ahead then updates both adjacency rows. A new item is taken only once
// the previous one has been placed in the result register.
// Reset (asynchronous, active low) clears the point count and the control state and sets
// the tolerance to 256; no clearing pass runs, since a row is zeroed when its point is added.
// ============================================================================
// point_graph_edge_table_top
// Point table with tolerance matching and a symmetric adjacency bit matrix.
// ============================================================================
module point_graph_edge_table_top
    import pget_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 24
)(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [TOL_W-1:0]              cfg_wdata,

    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [MODE_W-1:0]             mode,
    input  logic signed [COORD_BITS-1:0]  begin_x,
    input  logic signed [COORD_BITS-1:0]  begin_y,
    input  logic signed [COORD_BITS-1:0]  begin_z,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    input  logic signed [COORD_BITS-1:0]  end_z,

    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [OUT_IDX_W-1:0]          begin_index,
    output logic                          begin_found,
    output logic [OUT_IDX_W-1:0]          end_index,
    output logic                          end_found,
    output logic [STATUS_W-1:0]           status
);

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int NEED_W = CNT_W + 1;
    localparam int PT_W   = AXES * COORD_BITS;

    // Control state.
    state_t                 state_reg, state_next;
    logic [TOL_W-1:0]       tol_reg, tol_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;

    // Per-item working registers.
    logic [IDX_W-1:0]       scan_addr_reg, scan_addr_next;
    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic                   bf_reg, bf_next, ef_reg, ef_next;
    logic [IDX_W-1:0]       bi_reg, bi_next, ei_reg, ei_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [COORD_BITS-1:0]  bx_reg, by_reg, bz_reg, ex_reg, ey_reg, ez_reg;

    // Result register, which lets a new item in while a result waits.
    logic [OUT_IDX_W-1:0]   begin_index_reg, begin_index_next;
    logic [OUT_IDX_W-1:0]   end_index_reg, end_index_next;
    logic                   begin_found_reg, begin_found_next;
    logic                   end_found_reg, end_found_next;
    logic [STATUS_W-1:0]    status_out_reg, status_out_next;

    // Memory ports.
    logic                   pt_we, pt_re;
    logic [IDX_W-1:0]       pt_waddr;
    logic [PT_W-1:0]        pt_wdata, pt_rdata;
    logic                   edge_we, edge_re;
    logic [IDX_W-1:0]       edge_waddr, edge_raddr;
    logic [MAX_POINTS-1:0]  edge_wdata, edge_rdata;

    pget_tag_t              issue;
    pget_hit_t              hit;
    logic [IDX_W-1:0]       hit_idx;

    logic                   accept;
    logic                   out_free;
    logic                   scan_last;
    logic [1:0]             need;
    logic                   table_full;
    logic                   set_edge;
    logic [IDX_W-1:0]       count_idx;
    logic [MAX_POINTS-1:0]  col_mask;

    assign accept     = req_valid && (state_reg == S_IDLE);
    assign req_stall  = (state_reg != S_IDLE);
    assign out_free   = !out_valid_reg || !rsp_stall;
    assign count_idx  = count_reg[IDX_W-1:0];
    assign scan_last  = ((CNT_W'(scan_addr_reg) + CNT_W'(1)) == count_reg);
    assign need       = {1'b0, !bf_reg} + {1'b0, !ef_reg};
    assign table_full = (NEED_W'(count_reg) + NEED_W'(need)) > NEED_W'(MAX_POINTS);
    assign set_edge   = (mode_reg == MODE_ADD);

    // The x, y and z of one point share a memory word, x in the low bits.
    pget_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .re    (pt_re),
        .raddr (scan_addr_reg),
        .rdata (pt_rdata)
    );

    // One adjacency row per point. A row is written to zero when its point is
    // appended, so rows at or above the point count never need clearing.
    pget_ram #(
        .WIDTH (MAX_POINTS),
        .DEPTH (MAX_POINTS)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    pget_match #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .issue_idx (scan_addr_reg),
        .entry     (pt_rdata),
        .begin_pt  ({bz_reg, by_reg, bx_reg}),
        .end_pt    ({ez_reg, ey_reg, ex_reg}),
        .tol       (tol_reg),
        .hit       (hit),
        .hit_idx   (hit_idx)
    );

    // The column touched by the current row update: the other end of the edge.
    assign col_mask = MAX_POINTS'(1) << ((state_reg == S_EWR0) ? ei_reg : bi_reg);

    always_comb
    begin
        state_next       = state_reg;
        tol_next         = cfg_we ? cfg_wdata : tol_reg;
        count_next       = count_reg;
        scan_addr_next   = scan_addr_reg;
        mode_next        = mode_reg;
        bf_next          = bf_reg;
        ef_next          = ef_reg;
        bi_next          = bi_reg;
        ei_next          = ei_reg;
        status_next      = status_reg;

        out_valid_next   = out_valid_reg && rsp_stall;
        begin_index_next = begin_index_reg;
        end_index_next   = end_index_reg;
        begin_found_next = begin_found_reg;
        end_found_next   = end_found_reg;
        status_out_next  = status_out_reg;

        pt_we       = 1'b0;
        pt_re       = 1'b0;
        pt_waddr    = count_idx;
        pt_wdata    = {bz_reg, by_reg, bx_reg};
        edge_we     = 1'b0;
        edge_re     = 1'b0;
        edge_waddr  = bi_reg;
        edge_raddr  = bi_reg;
        edge_wdata  = '0;
        issue       = '0;

        // Entries come back in index order, so the first hit is the lowest match.
        // A query never looks for its end point.
        if (hit.valid)
        begin
            if (hit.begin_hit && !bf_reg)
            begin
                bf_next = 1'b1;
                bi_next = hit_idx;
            end
            if (hit.end_hit && !ef_reg &&
                (mode_reg == MODE_ADD || mode_reg == MODE_DEL))
            begin
                ef_next = 1'b1;
                ei_next = hit_idx;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next      = mode;
                    bf_next        = 1'b0;
                    ef_next        = 1'b0;
                    bi_next        = '0;
                    ei_next        = '0;
                    status_next    = STAT_DONE;
                    scan_addr_next = '0;
                    state_next     = (count_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                pt_re       = 1'b1;
                issue.valid = 1'b1;
                issue.last  = scan_last;
                if (scan_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (hit.valid && hit.last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (mode_reg)
                    MODE_ADD:
                    begin
                        if (table_full)
                        begin
                            status_next = STAT_FULL;
                            state_next  = S_FINISH;
                        end
                        else if (!bf_reg)
                        begin
                            state_next = S_APP_B;
                        end
                        else if (!ef_reg)
                        begin
                            state_next = S_APP_E;
                        end
                        else
                        begin
                            state_next = S_ERD0;
                        end
                    end
                    MODE_DEL:
                    begin
                        if (bf_reg && ef_reg)
                        begin
                            state_next = S_ERD0;
                        end
                        else
                        begin
                            status_next = STAT_SKIP;
                            state_next  = S_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_APP_B:
            begin
                pt_we      = 1'b1;
                pt_wdata   = {bz_reg, by_reg, bx_reg};
                edge_we    = 1'b1;
                edge_waddr = count_idx;
                bi_next    = count_idx;
                count_next = count_reg + CNT_W'(1);
                state_next = ef_reg ? S_ERD0 : S_APP_E;
            end
            S_APP_E:
            begin
                pt_we      = 1'b1;
                pt_wdata   = {ez_reg, ey_reg, ex_reg};
                edge_we    = 1'b1;
                edge_waddr = count_idx;
                ei_next    = count_idx;
                count_next = count_reg + CNT_W'(1);
                state_next = S_ERD0;
            end
            S_ERD0:
            begin
                edge_re    = 1'b1;
                edge_raddr = bi_reg;
                state_next = S_EWR0;
            end
            S_EWR0:
            begin
                edge_we    = 1'b1;
                edge_waddr = bi_reg;
                edge_wdata = set_edge ? (edge_rdata | col_mask) : (edge_rdata & ~col_mask);
                state_next = S_ERD1;
            end
            S_ERD1:
            begin
                // The write of the first row has landed, so a self edge reads it back.
                edge_re    = 1'b1;
                edge_raddr = ei_reg;
                state_next = S_EWR1;
            end
            S_EWR1:
            begin
                edge_we    = 1'b1;
                edge_waddr = ei_reg;
                edge_wdata = set_edge ? (edge_rdata | col_mask) : (edge_rdata & ~col_mask);
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    begin_index_next = OUT_IDX_W'(bi_reg);
                    end_index_next   = OUT_IDX_W'(ei_reg);
                    begin_found_next = bf_reg;
                    end_found_next   = ef_reg;
                    status_out_next  = status_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tol_reg       <= TOL_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tol_reg       <= tol_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg   <= scan_addr_next;
        mode_reg        <= mode_next;
        bf_reg          <= bf_next;
        ef_reg          <= ef_next;
        bi_reg          <= bi_next;
        ei_reg          <= ei_next;
        status_reg      <= status_next;
        begin_index_reg <= begin_index_next;
        end_index_reg   <= end_index_next;
        begin_found_reg <= begin_found_next;
        end_found_reg   <= end_found_next;
        status_out_reg  <= status_out_next;
        if (accept)
        begin
            bx_reg <= begin_x;
            by_reg <= begin_y;
            bz_reg <= begin_z;
            ex_reg <= end_x;
            ey_reg <= end_y;
            ez_reg <= end_z;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign begin_index = begin_index_reg;
    assign begin_found = begin_found_reg;
    assign end_index   = end_index_reg;
    assign end_found   = end_found_reg;
    assign status      = status_out_reg;

endmodule

>>> rtl/pget_checker.sv
// ============================================================================
// pget_checker
// Port-level checks of the point graph edge table, bound to the top level.
// ============================================================================
module pget_checker
    import pget_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_stall,
    input logic                  rsp_valid,
    input logic                  rsp_stall,
    input logic [OUT_IDX_W-1:0]  begin_index,
    input logic                  begin_found,
    input logic [OUT_IDX_W-1:0]  end_index,
    input logic                  end_found,
    input logic [STATUS_W-1:0]   status
);

    // Only one item is worked on at a time.
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another item is in work");

    // A full table can only be reported when at least one point was new.
    a_full_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STAT_FULL |-> !(begin_found && end_found))
        else $error("table full reported with both points found");

    // A skipped delete means a point was missing.
    a_skip_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STAT_SKIP |-> !(begin_found && end_found))
        else $error("delete skipped with both points found");

    // A point that has no entry after a failed request reports index zero.
    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STAT_DONE |->
            (begin_found || begin_index == '0) && (end_found || end_index == '0))
        else $error("missing point reported a nonzero index");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=>
            rsp_valid && $stable(begin_index) && $stable(end_index) && $stable(status))
        else $error("stalled result changed");

endmodule

bind point_graph_edge_table_top pget_checker u_pget_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .begin_index (begin_index),
    .begin_found (begin_found),
    .end_index   (end_index),
    .end_found   (end_found),
    .status      (status)
);

>>> sim/point_graph_edge_table_top_tb.sv
// ============================================================================
// point_graph_edge_table_top_tb
// Self-checking bench for the point table with tolerance matching.
// Requests are fed from a backlog by a clocked driver. Each accepted request is
// run through a behavioral copy of the point table, which yields the expected
// reply. A clocked monitor compares every reply with the oldest expected one.
// The table fills up over the run, so both the append path and the full-table
// path get exercised. The tolerance is moved through several settings between
// phases.
// ============================================================================
module point_graph_edge_table_top_tb
    import pget_pkg::*;
();

    localparam int CW      = 24;
    localparam int MAX_PTS = 64;

    // Mode 3 has no name in the package; the block treats it as a query.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam logic signed [CW-1:0] COORD_MIN = 24'sh800000;
    localparam logic signed [CW-1:0] COORD_MAX = 24'sh7FFFFF;

    localparam logic [TOL_W-1:0] TOL_MAX = 48'hFFFF_FFFF_FFFF;

    // One request item as it goes onto the wire.
    typedef struct {
        logic [MODE_W-1:0]    mode;
        logic signed [CW-1:0] bx, by, bz;
        logic signed [CW-1:0] ex, ey, ez;
    } request_t;

    // One reply item as the block is expected to return it.
    typedef struct {
        logic [OUT_IDX_W-1:0] begin_index;
        logic                 begin_found;
        logic [OUT_IDX_W-1:0] end_index;
        logic                 end_found;
        logic [STATUS_W-1:0]  status;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we = 1'b0;
    logic [TOL_W-1:0]     cfg_wdata = '0;

    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic [MODE_W-1:0]    mode = MODE_QUERY;
    logic signed [CW-1:0] begin_x = '0;
    logic signed [CW-1:0] begin_y = '0;
    logic signed [CW-1:0] begin_z = '0;
    logic signed [CW-1:0] end_x = '0;
    logic signed [CW-1:0] end_y = '0;
    logic signed [CW-1:0] end_z = '0;

    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic [OUT_IDX_W-1:0] begin_index;
    logic                 begin_found;
    logic [OUT_IDX_W-1:0] end_index;
    logic                 end_found;
    logic [STATUS_W-1:0]  status;

    // Behavioral copy of the table. The adjacency bits never reach the reply
    // port, so only the points, the count and the tolerance are tracked here.
    logic signed [CW-1:0] pts_x [MAX_PTS];
    logic signed [CW-1:0] pts_y [MAX_PTS];
    logic signed [CW-1:0] pts_z [MAX_PTS];
    int                   stored_count = 0;
    logic [TOL_W-1:0]     tol_model = TOL_RESET;

    request_t request_backlog[$];
    reply_t   expected_replies[$];
    request_t on_wire;
    reply_t   oldest_reply;

    int send_gap = 0;
    int rsp_hold = 0;
    int replies_seen = 0;
    int errors = 0;

    // While set, neither side idles, so requests run back to back.
    bit steady = 1'b0;

    point_graph_edge_table_top #(
        .MAX_POINTS (MAX_PTS),
        .COORD_BITS (CW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .mode        (mode),
        .begin_x     (begin_x),
        .begin_y     (begin_y),
        .begin_z     (begin_z),
        .end_x       (end_x),
        .end_y       (end_y),
        .end_z       (end_z),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .begin_index (begin_index),
        .begin_found (begin_found),
        .end_index   (end_index),
        .end_found   (end_found),
        .status      (status)
    );

    always #4 clk = ~clk;

    // A coordinate drawn over the full range.
    function automatic logic signed [CW-1:0] rand_coord();
        return CW'($urandom);
    endfunction

    // Square of one coordinate difference. A magnitude of 2^24 or more
    // saturates to 2^48, which no tolerance can exceed.
    function automatic longint unsigned axis_sq(logic signed [CW-1:0] a,
                                                logic signed [CW-1:0] b);
        longint          d;
        longint unsigned m;
        d = longint'(a) - longint'(b);
        m = (d < 0) ? -d : d;
        if (m >= (64'd1 << 24))
            return 64'd1 << 48;
        return m * m;
    endfunction

    // Finds the lowest stored index strictly within the tolerance of a point.
    function automatic bit locate_point(logic signed [CW-1:0] x,
                                        logic signed [CW-1:0] y,
                                        logic signed [CW-1:0] z,
                                        output int idx);
        longint unsigned sq_sum;
        idx = 0;
        for (int i = 0; i < stored_count; i++)
        begin
            sq_sum = axis_sq(x, pts_x[i]) + axis_sq(y, pts_y[i]) + axis_sq(z, pts_z[i]);
            if (sq_sum < {16'd0, tol_model})
            begin
                idx = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one request to the behavioral table and returns its reply.
    function automatic reply_t resolve_request(request_t rq);
        reply_t rp;
        int     bi;
        int     ei;
        int     need;
        bit     bf;
        bit     ef;
        ei = 0;
        ef = 1'b0;
        rp.status = STAT_DONE;
        bf = locate_point(rq.bx, rq.by, rq.bz, bi);
        if (rq.mode == MODE_ADD)
        begin
            ef = locate_point(rq.ex, rq.ey, rq.ez, ei);
            need = (bf ? 0 : 1) + (ef ? 0 : 1);
            if (stored_count + need > MAX_PTS)
            begin
                rp.status = STAT_FULL;
            end
            else
            begin
                // Begin goes in first, then end, even when the two lie close.
                if (!bf)
                begin
                    bi = stored_count;
                    pts_x[bi] = rq.bx;
                    pts_y[bi] = rq.by;
                    pts_z[bi] = rq.bz;
                    stored_count++;
                end
                if (!ef)
                begin
                    ei = stored_count;
                    pts_x[ei] = rq.ex;
                    pts_y[ei] = rq.ey;
                    pts_z[ei] = rq.ez;
                    stored_count++;
                end
            end
        end
        else if (rq.mode == MODE_DEL)
        begin
            ef = locate_point(rq.ex, rq.ey, rq.ez, ei);
            if (!(bf && ef))
                rp.status = STAT_SKIP;
        end
        rp.begin_index = bi[OUT_IDX_W-1:0];
        rp.begin_found = bf;
        rp.end_index   = ei[OUT_IDX_W-1:0];
        rp.end_found   = ef;
        return rp;
    endfunction

    task automatic log_mismatch(string msg);
        errors++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // Driver. The expected reply is worked out at the edge that accepts a
    // request, so the table copy advances in the same order as the block.
    // After each accepted item the driver sits out the gap drawn for it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            mode      <= MODE_QUERY;
            begin_x   <= '0;
            begin_y   <= '0;
            begin_z   <= '0;
            end_x     <= '0;
            end_y     <= '0;
            end_z     <= '0;
            send_gap = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_replies.insert(expected_replies.size(), resolve_request(on_wire));
            if (!req_valid || !req_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (request_backlog.size() > 0)
                begin
                    on_wire = request_backlog.pop_front();
                    mode      <= on_wire.mode;
                    begin_x   <= on_wire.bx;
                    begin_y   <= on_wire.by;
                    begin_z   <= on_wire.bz;
                    end_x     <= on_wire.ex;
                    end_y     <= on_wire.ey;
                    end_z     <= on_wire.ez;
                    req_valid <= 1'b1;
                    send_gap = steady ? 0 : $urandom_range(0, 4);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each reply is held off for a drawn number of valid cycles
    // before it is taken, then checked field by field.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_hold = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                replies_seen++;
                if (expected_replies.size() == 0)
                begin
                    log_mismatch($sformatf("reply %0d arrived with no request outstanding",
                                           replies_seen));
                end
                else
                begin
                    oldest_reply = expected_replies.pop_front();
                    if (begin_index !== oldest_reply.begin_index)
                        log_mismatch($sformatf("reply %0d begin_index %0d, expected %0d",
                            replies_seen, begin_index, oldest_reply.begin_index));
                    if (begin_found !== oldest_reply.begin_found)
                        log_mismatch($sformatf("reply %0d begin_found %0d, expected %0d",
                            replies_seen, begin_found, oldest_reply.begin_found));
                    if (end_index !== oldest_reply.end_index)
                        log_mismatch($sformatf("reply %0d end_index %0d, expected %0d",
                            replies_seen, end_index, oldest_reply.end_index));
                    if (end_found !== oldest_reply.end_found)
                        log_mismatch($sformatf("reply %0d end_found %0d, expected %0d",
                            replies_seen, end_found, oldest_reply.end_found));
                    if (status !== oldest_reply.status)
                        log_mismatch($sformatf("reply %0d status %0d, expected %0d",
                            replies_seen, status, oldest_reply.status));
                end
                rsp_hold = steady ? 0 : $urandom_range(0, 4);
            end
            else if (rsp_valid && rsp_hold > 0)
            begin
                rsp_hold--;
            end
            rsp_stall <= (rsp_hold > 0);
        end
    end

    // Queues one request. The backlog is kept short so that points picked
    // from the table copy are never far behind the block.
    task automatic send(logic [MODE_W-1:0] m,
                        logic signed [CW-1:0] bx, logic signed [CW-1:0] by,
                        logic signed [CW-1:0] bz, logic signed [CW-1:0] ex,
                        logic signed [CW-1:0] ey, logic signed [CW-1:0] ez);
        request_t rq;
        rq.mode = m;
        rq.bx = bx;
        rq.by = by;
        rq.bz = bz;
        rq.ex = ex;
        rq.ey = ey;
        rq.ez = ez;
        while (request_backlog.size() >= 2)
            @(negedge clk);
        request_backlog.insert(request_backlog.size(), rq);
    endtask

    task automatic wait_idle();
        while (request_backlog.size() != 0 || req_valid || expected_replies.size() != 0)
            @(negedge clk);
    endtask

    // The tolerance only changes while nothing is in flight.
    task automatic write_tolerance(logic [TOL_W-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tol_model = value;
    endtask

    // A point is either fresh (full range, or clustered near the origin so
    // that several entries can compete for one probe) or a stored point,
    // taken exactly or nudged by a few units around the tolerance radius.
    task automatic pick_point(int new_pct, output logic signed [CW-1:0] x,
                              output logic signed [CW-1:0] y,
                              output logic signed [CW-1:0] z);
        int k;
        if (stored_count == 0 || $urandom_range(0, 99) < new_pct)
        begin
            if ($urandom_range(0, 1))
            begin
                x = rand_coord();
                y = rand_coord();
                z = rand_coord();
            end
            else
            begin
                x = CW'($urandom_range(0, 511) - 256);
                y = CW'($urandom_range(0, 511) - 256);
                z = CW'($urandom_range(0, 511) - 256);
            end
        end
        else
        begin
            k = $urandom_range(0, stored_count - 1);
            x = pts_x[k];
            y = pts_y[k];
            z = pts_z[k];
            if ($urandom_range(0, 2) != 0)
            begin
                x = CW'(x + ($urandom_range(0, 24) - 12));
                y = CW'(y + ($urandom_range(0, 24) - 12));
                z = CW'(z + ($urandom_range(0, 24) - 12));
            end
        end
    endtask

    // Mostly adds and deletes over points the table already knows, with a
    // share of queries and the unused mode.
    task automatic random_request(int new_pct);
        logic [MODE_W-1:0]    m;
        logic signed [CW-1:0] bx, by, bz, ex, ey, ez;
        int                   roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            m = MODE_ADD;
        else if (roll < 70)
            m = MODE_DEL;
        else if (roll < 92)
            m = MODE_QUERY;
        else
            m = MODE_SPARE;
        pick_point(new_pct, bx, by, bz);
        pick_point(new_pct, ex, ey, ez);
        send(m, bx, by, bz, ex, ey, ez);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset tolerance, starting from an empty table.
        // Lookups on an empty table miss in every mode.
        send(MODE_QUERY, 0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX);
        send(MODE_DEL, 0, 0, 0, 0, 0, 0);
        send(MODE_SPARE, COORD_MIN, COORD_MAX, 0, COORD_MIN, COORD_MIN, COORD_MIN);
        // Two new points within the tolerance of each other still take two entries.
        send(MODE_ADD, 0, 0, 0, 5, 0, 0);
        // Both ends resolve to one entry: the diagonal bit.
        send(MODE_ADD, 0, 0, 0, 1, 1, 1);
        // Opposite corners of the coordinate range.
        send(MODE_ADD, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        // Exactly on the tolerance radius misses; one unit inside hits.
        send(MODE_QUERY, CW'(COORD_MIN + 16), COORD_MIN, COORD_MIN, 0, 0, 0);
        send(MODE_QUERY, CW'(COORD_MIN + 15), COORD_MIN, COORD_MIN, 0, 0, 0);
        // Matches two entries; the lower index wins.
        send(MODE_QUERY, 3, 0, 0, 0, 0, 0);
        send(MODE_DEL, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        // Delete with the end missing, then with the begin missing.
        send(MODE_DEL, COORD_MAX, COORD_MAX, COORD_MAX, 1000, 1000, 1000);
        send(MODE_DEL, 1000, 1000, 1000, 0, 0, 0);
        send(MODE_DEL, 2, 2, 2, 0, 0, 0);
        // Only one end new, each way round.
        send(MODE_ADD, 4096, -4096, 4096, 0, 0, 0);
        send(MODE_ADD, COORD_MAX, COORD_MAX, COORD_MAX, -300, -300, -300);
        // The unused mode behaves as a query and ignores the end point.
        send(MODE_SPARE, CW'(COORD_MAX - 10), COORD_MAX, COORD_MAX, 7, 7, 7);
        send(MODE_QUERY, COORD_MAX, COORD_MIN, 0, COORD_MIN, COORD_MAX, -1);

        // Let the table grow with random traffic, stopping well short of full.
        while (stored_count < 52)
            random_request(15);

        // Walk the count up to one free entry, then probe the full boundary.
        wait_idle();
        while (stored_count < MAX_PTS - 1)
        begin
            send(MODE_ADD, rand_coord(), rand_coord(), rand_coord(),
                 pts_x[0], pts_y[0], pts_z[0]);
            wait_idle();
        end
        // Two new points do not fit into one free entry.
        send(MODE_ADD, rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord());
        // One new point takes the last entry.
        send(MODE_ADD, pts_x[1], pts_y[1], pts_z[1], rand_coord(), rand_coord(), rand_coord());
        // Full table: a new point fails, but the found end is still reported.
        send(MODE_ADD, rand_coord(), rand_coord(), rand_coord(), pts_x[2], pts_y[2], pts_z[2]);
        send(MODE_ADD, pts_x[3], pts_y[3], pts_z[3], pts_x[2], pts_y[2], pts_z[2]);

        // Full table at the reset tolerance, part of it back to back.
        repeat (350) random_request(10);
        steady = 1'b1;
        repeat (150) random_request(10);
        steady = 1'b0;

        // Zero tolerance: nothing matches, so adds fail and deletes are skipped.
        write_tolerance('0);
        repeat (150) random_request(10);

        // Largest tolerance: almost every probe lands on the first entry.
        write_tolerance(TOL_MAX);
        repeat (150) random_request(10);

        // A wide tolerance somewhere in between.
        write_tolerance(48'($urandom_range(1 << 12, 1 << 22)));
        repeat (300) random_request(20);

        write_tolerance(TOL_RESET);
        repeat (550) random_request(10);

        wait_idle();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // A watchdog stops a run that hangs and reports it as a failure.
    initial
    begin
        #8000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
rtl/pget_pkg.sv
rtl/pget_ram.sv
rtl/pget_match.sv
rtl/point_graph_edge_table_top.sv
rtl/pget_checker.sv
sim/point_graph_edge_table_top_tb.sv
